// ===== rtl/bfhp_pkg.sv =====
`default_nettype none

package bfhp_pkg;

    localparam int HEAP_SLOTS  = 16;
    localparam int SIZE_BITS   = 48;
    localparam int SLOT_BITS   = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
    localparam int STAMP_W     = 32;
    localparam int LIMIT_W     = 8;
    localparam int FREED_W     = 5;
    localparam int SLOT_OUT_W  = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

    typedef enum logic {
        CMD_FRAME   = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_REUSED  = 2'd0,
        ST_CREATED = 2'd1,
        ST_NO_ROOM = 2'd2,
        ST_FRAME   = 2'd3
    } status_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] bytes;
        logic [STAMP_W-1:0]   last_frame;
        logic [STAMP_W-1:0]   birth;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] heap_slot;
        logic [SIZE_BITS-1:0]  heap_bytes;
        logic [FREED_W-1:0]    freed_count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bfhp_intf.sv =====
`default_nettype none

interface bfhp_req_if;
    logic                           valid;
    logic                           ready;
    bfhp_pkg::cmd_t                 cmd;
    logic [bfhp_pkg::SIZE_BITS-1:0] req_size;

    modport source (output valid, output cmd, output req_size, input ready);
    modport sink   (input valid, input cmd, input req_size, output ready);
endinterface

interface bfhp_rsp_if;
    logic                            valid;
    logic                            ready;
    bfhp_pkg::status_t               status;
    logic [bfhp_pkg::SLOT_OUT_W-1:0] heap_slot;
    logic [bfhp_pkg::SIZE_BITS-1:0]  heap_bytes;
    logic [bfhp_pkg::FREED_W-1:0]    freed_count;

    modport source (output valid, output status, output heap_slot, output heap_bytes,
                    output freed_count, input ready);
    modport sink   (input valid, input status, input heap_slot, input heap_bytes,
                    input freed_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfhp_ram.sv =====
`default_nettype none

module bfhp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bfhp_ctrl.sv =====
`default_nettype none

module bfhp_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bfhp_req_if.sink                              req,
    input  wire logic [bfhp_pkg::LIMIT_W-1:0]     idle_frame_limit,
    output logic                                  res_valid,
    output bfhp_pkg::rsp_t                        res,
    input  wire logic                             res_ready
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FINISH
    } state_t;

    localparam logic [bfhp_pkg::SLOT_BITS-1:0] LAST_SLOT =
        bfhp_pkg::SLOT_BITS'(bfhp_pkg::HEAP_SLOTS - 1);

    state_t                              state_reg;
    bfhp_pkg::cmd_t                      cmd_reg;
    logic [bfhp_pkg::SIZE_BITS-1:0]      want_reg;
    logic [bfhp_pkg::SLOT_BITS-1:0]      rd_idx_reg;
    logic                                issue_done_reg;
    logic                                cmp_vld_reg;
    logic [bfhp_pkg::SLOT_BITS-1:0]      cmp_idx_reg;
    logic [bfhp_pkg::HEAP_SLOTS-1:0]     valid_reg;
    logic [bfhp_pkg::STAMP_W-1:0]        frame_reg;
    logic [bfhp_pkg::STAMP_W-1:0]        birth_reg;
    logic                                found_reg;
    logic [bfhp_pkg::SLOT_BITS-1:0]      best_idx_reg;
    logic [bfhp_pkg::SIZE_BITS-1:0]      best_bytes_reg;
    logic [bfhp_pkg::STAMP_W-1:0]        best_age_reg;
    logic [bfhp_pkg::STAMP_W-1:0]        best_birth_reg;
    logic                                free_found_reg;
    logic [bfhp_pkg::SLOT_BITS-1:0]      free_idx_reg;
    logic [bfhp_pkg::FREED_W-1:0]        freed_reg;

    logic [bfhp_pkg::ENTRY_W-1:0]        ram_rdata;
    logic [bfhp_pkg::ENTRY_W-1:0]        ram_wdata;
    logic [bfhp_pkg::SLOT_BITS-1:0]      ram_waddr;
    logic                                ram_we;
    logic                                ram_re;

    bfhp_pkg::entry_t                    cur;
    logic                                cur_valid;
    logic [bfhp_pkg::STAMP_W-1:0]        cur_age;
    logic [bfhp_pkg::STAMP_W-1:0]        idle_gap;
    logic                                fits;
    logic                                better;
    logic                                expire;
    logic                                accept;
    logic                                res_fire;
    logic                                do_create;
    logic                                do_reuse;

    bfhp_ram #(
        .DEPTH (bfhp_pkg::HEAP_SLOTS),
        .WIDTH (bfhp_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == IDLE);
    assign accept    = req.valid && (state_reg == IDLE);
    assign ram_re    = (state_reg == SCAN) && !issue_done_reg;

    // compare stage on the entry read last cycle
    assign cur       = bfhp_pkg::entry_t'(ram_rdata);
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_age   = birth_reg - cur.birth;
    assign idle_gap  = frame_reg - cur.last_frame;
    assign fits      = cur_valid && (cur.bytes >= want_reg) && (cur.last_frame != frame_reg);
    assign better    = !found_reg || (cur.bytes < best_bytes_reg) ||
                       ((cur.bytes == best_bytes_reg) && (cur_age > best_age_reg));
    assign expire    = cur_valid && (idle_gap > bfhp_pkg::STAMP_W'(idle_frame_limit));

    always_comb
    begin
        res.status      = bfhp_pkg::ST_NO_ROOM;
        res.heap_slot   = '0;
        res.heap_bytes  = '0;
        res.freed_count = '0;
        if (cmd_reg == bfhp_pkg::CMD_FRAME)
        begin
            res.status      = bfhp_pkg::ST_FRAME;
            res.freed_count = freed_reg;
        end
        else if (found_reg)
        begin
            res.status     = bfhp_pkg::ST_REUSED;
            res.heap_slot  = bfhp_pkg::SLOT_OUT_W'(best_idx_reg);
            res.heap_bytes = best_bytes_reg;
        end
        else if (free_found_reg)
        begin
            res.status     = bfhp_pkg::ST_CREATED;
            res.heap_slot  = bfhp_pkg::SLOT_OUT_W'(free_idx_reg);
            res.heap_bytes = want_reg;
        end
    end

    assign res_valid = (state_reg == FINISH);
    assign res_fire  = res_valid && res_ready;
    assign do_reuse  = (cmd_reg == bfhp_pkg::CMD_REQUEST) && found_reg;
    assign do_create = (cmd_reg == bfhp_pkg::CMD_REQUEST) && !found_reg && free_found_reg;
    assign ram_we    = res_fire && (do_reuse || do_create);
    assign ram_waddr = found_reg ? best_idx_reg : free_idx_reg;
    assign ram_wdata = found_reg ? {best_bytes_reg, frame_reg, best_birth_reg}
                                 : {want_reg, frame_reg, birth_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            cmd_reg        <= bfhp_pkg::CMD_FRAME;
            want_reg       <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            valid_reg      <= '0;
            frame_reg      <= '0;
            birth_reg      <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_bytes_reg <= '0;
            best_age_reg   <= '0;
            best_birth_reg <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            freed_reg      <= '0;
        end
        else
        begin
            cmp_vld_reg <= (state_reg == SCAN) && !issue_done_reg;
            cmp_idx_reg <= rd_idx_reg;
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        state_reg      <= SCAN;
                        cmd_reg        <= req.cmd;
                        want_reg       <= req.req_size;
                        rd_idx_reg     <= '0;
                        issue_done_reg <= 1'b0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        freed_reg      <= '0;
                        if (req.cmd == bfhp_pkg::CMD_FRAME)
                        begin
                            frame_reg <= frame_reg + 1'b1;
                        end
                    end
                end
                SCAN:
                begin
                    if (!issue_done_reg)
                    begin
                        if (rd_idx_reg == LAST_SLOT)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                    end
                    if (cmp_vld_reg)
                    begin
                        if (cmd_reg == bfhp_pkg::CMD_FRAME)
                        begin
                            if (expire)
                            begin
                                valid_reg[cmp_idx_reg] <= 1'b0;
                                freed_reg              <= freed_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            if (fits && better)
                            begin
                                found_reg      <= 1'b1;
                                best_idx_reg   <= cmp_idx_reg;
                                best_bytes_reg <= cur.bytes;
                                best_age_reg   <= cur_age;
                                best_birth_reg <= cur.birth;
                            end
                            if (!cur_valid && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= cmp_idx_reg;
                            end
                        end
                        if (cmp_idx_reg == LAST_SLOT)
                        begin
                            state_reg <= FINISH;
                        end
                    end
                end
                FINISH:
                begin
                    if (res_fire)
                    begin
                        state_reg <= IDLE;
                        if (do_create)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            birth_reg               <= birth_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (cmp_idx_reg == $past(rd_idx_reg)))
        else $error("compare index out of step with read index");

    a_birth_only_on_create: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_fire && do_create) |=> $stable(birth_reg))
        else $error("birth counter moved without a new heap");

    a_frame_stable_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN) |=> $stable(frame_reg))
        else $error("frame counter moved during a scan");

    a_reuse_is_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && (res.status == bfhp_pkg::ST_REUSED)) |->
            (valid_reg[best_idx_reg] && (best_bytes_reg >= want_reg)))
        else $error("reused heap is not a valid fit");

    a_no_room_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && (res.status == bfhp_pkg::ST_NO_ROOM)) |-> (&valid_reg))
        else $error("no room reported with a free slot");

endmodule

`default_nettype wire

// ===== rtl/best_fit_heap_pool_with_aging.sv =====
// flow: an item is taken in IDLE, SCAN reads every slot and compares it, FINISH hands the result
// to the result register, whose beat is then valid; a new item is taken only in IDLE, and the scan
//   of one slot per cycle through the read port of the entry memory sets how often items pass
// the result register lets the next item start while a result beat waits
// reset: pool empty, frame and birth counters zero, idle_frame_limit 3, no clearing pass
`default_nettype none

module best_fit_heap_pool_with_aging (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bfhp_req_if.sink                          req,
    bfhp_rsp_if.source                        rsp,
    input  wire logic                         cfg_we,
    input  wire logic [bfhp_pkg::LIMIT_W-1:0] cfg_wdata
);

    logic [bfhp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         out_valid_reg;
    bfhp_pkg::rsp_t               out_data_reg;
    logic                         res_valid;
    bfhp_pkg::rsp_t               res;
    logic                         res_ready;

    bfhp_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req),
        .idle_frame_limit (limit_reg),
        .res_valid        (res_valid),
        .res              (res),
        .res_ready        (res_ready)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= bfhp_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= res;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.heap_slot   = out_data_reg.heap_slot;
    assign rsp.heap_bytes  = out_data_reg.heap_bytes;
    assign rsp.freed_count = out_data_reg.freed_count;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bfhp_pkg::SIZE_BITS-1:0] SIZE_MAX = '1;
    localparam int OPENING_ROWS = 25;
    localparam int PHASE_ITEMS = 345;
    localparam int PHASES = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        bfhp_pkg::cmd_t                 op;
        logic [bfhp_pkg::SIZE_BITS-1:0] size;
        bit                             typed;
        bfhp_pkg::status_t              st;
        int                             slot;
        logic [bfhp_pkg::SIZE_BITS-1:0] bytes;
        int                             freed;
    } opening_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [bfhp_pkg::LIMIT_W-1:0] cfg_wdata;

    bfhp_req_if req_bus ();
    bfhp_rsp_if rsp_bus ();

    best_fit_heap_pool_with_aging u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pool shadow
    logic                           pool_live  [bfhp_pkg::HEAP_SLOTS];
    logic [bfhp_pkg::SIZE_BITS-1:0] pool_bytes [bfhp_pkg::HEAP_SLOTS];
    logic [bfhp_pkg::STAMP_W-1:0]   pool_last  [bfhp_pkg::HEAP_SLOTS];
    logic [bfhp_pkg::STAMP_W-1:0]   pool_birth [bfhp_pkg::HEAP_SLOTS];
    logic [bfhp_pkg::STAMP_W-1:0]   frame_now = '0;
    logic [bfhp_pkg::STAMP_W-1:0]   births = '0;
    logic [bfhp_pkg::LIMIT_W-1:0]   idle_limit = bfhp_pkg::LIMIT_RESET;

    bfhp_pkg::rsp_t heap_results [$];
    bfhp_pkg::rsp_t heap_due;
    int   fail_count = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;
    bit   pressure_go = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;

    initial
    begin
        for (int i = 0; i < bfhp_pkg::HEAP_SLOTS; i++)
        begin
            pool_live[i] = 1'b0;
            pool_bytes[i] = '0;
            pool_last[i] = '0;
            pool_birth[i] = '0;
        end
    end

    function automatic bfhp_pkg::rsp_t pool_step(input bfhp_pkg::cmd_t op,
                                                 input logic [bfhp_pkg::SIZE_BITS-1:0] want);
        bfhp_pkg::rsp_t r;
        int best;
        int freed;
        logic [bfhp_pkg::STAMP_W-1:0] age_i;
        logic [bfhp_pkg::STAMP_W-1:0] age_b;
        r = '0;
        if (op == bfhp_pkg::CMD_FRAME)
        begin
            freed = 0;
            frame_now = frame_now + 1'b1;
            for (int i = 0; i < bfhp_pkg::HEAP_SLOTS; i++)
            begin
                age_i = frame_now - pool_last[i];
                if (pool_live[i] && age_i > bfhp_pkg::STAMP_W'(idle_limit))
                begin
                    pool_live[i] = 1'b0;
                    freed++;
                end
            end
            r.status = bfhp_pkg::ST_FRAME;
            r.freed_count = bfhp_pkg::FREED_W'(freed);
            return r;
        end
        best = -1;
        for (int i = 0; i < bfhp_pkg::HEAP_SLOTS; i++)
        begin
            if (!pool_live[i] || pool_bytes[i] < want || pool_last[i] == frame_now)
                continue;
            if (best < 0)
                best = i;
            else
            begin
                age_i = births - pool_birth[i];
                age_b = births - pool_birth[best];
                if (pool_bytes[i] < pool_bytes[best] ||
                    (pool_bytes[i] == pool_bytes[best] && age_i > age_b))
                    best = i;
            end
        end
        if (best >= 0)
        begin
            pool_last[best] = frame_now;
            r.status = bfhp_pkg::ST_REUSED;
            r.heap_slot = bfhp_pkg::SLOT_OUT_W'(best);
            r.heap_bytes = pool_bytes[best];
            return r;
        end
        for (int i = 0; i < bfhp_pkg::HEAP_SLOTS; i++)
        begin
            if (!pool_live[i])
            begin
                pool_live[i] = 1'b1;
                pool_bytes[i] = want;
                pool_last[i] = frame_now;
                pool_birth[i] = births;
                births = births + 1'b1;
                r.status = bfhp_pkg::ST_CREATED;
                r.heap_slot = bfhp_pkg::SLOT_OUT_W'(i);
                r.heap_bytes = want;
                return r;
            end
        end
        r.status = bfhp_pkg::ST_NO_ROOM;
        return r;
    endfunction

    function automatic logic [bfhp_pkg::SIZE_BITS-1:0] pick_size();
        logic [bfhp_pkg::SIZE_BITS-1:0] s;
        case ($urandom_range(0, 9)) inside
            [0:3]:   s = bfhp_pkg::SIZE_BITS'($urandom_range(0, 5) * 256);
            [4:5]:   s = bfhp_pkg::SIZE_BITS'($urandom_range(0, 65535));
            [6:7]:   s = bfhp_pkg::SIZE_BITS'({$urandom(), $urandom()});
            8:       s = SIZE_MAX - bfhp_pkg::SIZE_BITS'($urandom_range(0, 3));
            default: s = '0;
        endcase
        return s;
    endfunction

    // called and returns at a falling edge
    task automatic send_heap_op(input bfhp_pkg::cmd_t op,
                                input logic [bfhp_pkg::SIZE_BITS-1:0] size,
                                input bit typed, input bfhp_pkg::rsp_t golden);
        int gap;
        bfhp_pkg::rsp_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.cmd <= op;
        req_bus.req_size <= size;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predicted = pool_step(op, size);
        heap_results.insert(heap_results.size(), typed ? golden : predicted);
        @(negedge clk);
    endtask

    task automatic set_idle_limit(input logic [bfhp_pkg::LIMIT_W-1:0] value);
        req_bus.valid <= 1'b0;
        while (heap_results.size() != 0)
            @(negedge clk);
        repeat (bfhp_pkg::HEAP_SLOTS + 6) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        idle_limit = value;
    endtask

    opening_row_t opening_rows [OPENING_ROWS] = '{
        '{bfhp_pkg::CMD_REQUEST, 48'd0,   1'b1, bfhp_pkg::ST_CREATED, 0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, SIZE_MAX, 1'b1, bfhp_pkg::ST_CREATED, 1, SIZE_MAX, 0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b1, bfhp_pkg::ST_CREATED, 2, 48'd100,  0},
        '{bfhp_pkg::CMD_FRAME,   48'd0,   1'b1, bfhp_pkg::ST_FRAME,   0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd50,  1'b1, bfhp_pkg::ST_REUSED,  2, 48'd100,  0},
        '{bfhp_pkg::CMD_REQUEST, 48'd0,   1'b1, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b1, bfhp_pkg::ST_REUSED,  1, SIZE_MAX, 0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b1, bfhp_pkg::ST_CREATED, 3, 48'd100,  0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd7,   1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, SIZE_MAX, 1'b0, bfhp_pkg::ST_REUSED, 0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'h555555555555, 1'b0, bfhp_pkg::ST_REUSED, 0, 48'd0, 0},
        '{bfhp_pkg::CMD_REQUEST, 48'haaaaaaaaaaaa, 1'b0, bfhp_pkg::ST_REUSED, 0, 48'd0, 0},
        '{bfhp_pkg::CMD_REQUEST, 48'd256, 1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd256, 1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd0,   1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd1,   1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd100, 1'b0, bfhp_pkg::ST_REUSED,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_REQUEST, 48'd1,   1'b1, bfhp_pkg::ST_NO_ROOM, 0, 48'd0,    0},
        '{bfhp_pkg::CMD_FRAME,   SIZE_MAX, 1'b1, bfhp_pkg::ST_FRAME,  0, 48'd0,    0},
        '{bfhp_pkg::CMD_FRAME,   48'd0,   1'b1, bfhp_pkg::ST_FRAME,   0, 48'd0,    0},
        '{bfhp_pkg::CMD_FRAME,   48'd0,   1'b1, bfhp_pkg::ST_FRAME,   0, 48'd0,    0},
        '{bfhp_pkg::CMD_FRAME,   48'd0,   1'b1, bfhp_pkg::ST_FRAME,   0, 48'd0,    16}
    };

    initial
    begin : stimulus
        bfhp_pkg::rsp_t golden;
        logic [bfhp_pkg::LIMIT_W-1:0] lim;
        bfhp_pkg::cmd_t op;
        req_bus.valid <= 1'b0;
        req_bus.cmd <= bfhp_pkg::CMD_FRAME;
        req_bus.req_size <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < OPENING_ROWS; i++)
        begin
            golden = '0;
            golden.status = opening_rows[i].st;
            golden.heap_slot = bfhp_pkg::SLOT_OUT_W'(opening_rows[i].slot);
            golden.heap_bytes = opening_rows[i].bytes;
            golden.freed_count = bfhp_pkg::FREED_W'(opening_rows[i].freed);
            send_heap_op(opening_rows[i].op, opening_rows[i].size, opening_rows[i].typed,
                         golden);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = bfhp_pkg::LIMIT_W'($urandom_range(2, 254));
                3:       lim = bfhp_pkg::LIMIT_W'(1);
                default: lim = bfhp_pkg::LIMIT_RESET;
            endcase
            set_idle_limit(lim);
            if (phase == 1)
                pressure_go = 1'b1;
            if (phase == PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(0, 5) == 0) ? bfhp_pkg::CMD_FRAME : bfhp_pkg::CMD_REQUEST;
                send_heap_op(op, pick_size(), 1'b0, '0);
            end
        end
        req_bus.valid <= 1'b0;

        while (heap_results.size() != 0)
            @(posedge clk);
        repeat (bfhp_pkg::HEAP_SLOTS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        rsp_bus.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_go)
            begin
                pressure_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (heap_results.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                fail_count++;
            end
            else
            begin
                heap_due = heap_results.pop_front();
                if (rsp_bus.status !== heap_due.status)
                begin
                    $error("status expected %0d got %0d", heap_due.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.heap_slot !== heap_due.heap_slot)
                begin
                    $error("heap_slot expected %0d got %0d", heap_due.heap_slot,
                           rsp_bus.heap_slot);
                    fail_count++;
                end
                if (rsp_bus.heap_bytes !== heap_due.heap_bytes)
                begin
                    $error("heap_bytes expected %0h got %0h", heap_due.heap_bytes,
                           rsp_bus.heap_bytes);
                    fail_count++;
                end
                if (rsp_bus.freed_count !== heap_due.freed_count)
                begin
                    $error("freed_count expected %0d got %0d", heap_due.freed_count,
                           rsp_bus.freed_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bfhp_pkg.sv
rtl/bfhp_intf.sv
rtl/bfhp_ram.sv
rtl/bfhp_ctrl.sv
rtl/best_fit_heap_pool_with_aging.sv
test/testbench.sv
